/* rtl/matrix_multiply_macros.svh */
// ----------------------------------------------------------------------------
// matrix_multiply assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_MACROS_SVH
`define MATRIX_MULTIPLY_MACROS_SVH

`ifndef SYNTHESIS
// property checked outside reset
`define MM_ASSERT(name, ck, rs, prop, msg) \
  name: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// property checked at every edge, reset included
`define MM_ASSERT_ALWAYS(name, ck, prop, msg) \
  name: assert property (@(posedge ck) prop) else $error(msg);
`else
`define MM_ASSERT(name, ck, rs, prop, msg)
`define MM_ASSERT_ALWAYS(name, ck, prop, msg)
`endif

`endif

/* rtl/mm_pkg.sv */
// ----------------------------------------------------------------------------
// mm_pkg
// shared types, constants and helpers of the matrix multiplier
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int MAX_DIM     = 8;
  localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // field widths
  localparam int OP_W       = 2;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 3;
  localparam int VAL_W      = 32;
  localparam int DIM_W      = 4;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = ROW_W + COL_W + VAL_W;
  localparam int TDATA_W    = ((DATA_W + 7) / 8) * 8;
  localparam int PAD_W      = TDATA_W - DATA_W;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int ACC_W      = PROD_W + IDX_W;

  // field positions in tdata
  localparam int ROW_LSB = 0;
  localparam int COL_LSB = ROW_W;
  localparam int VAL_LSB = ROW_W + COL_W;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = DIM_W;
  localparam logic [CFG_INDEX_W-1:0] REG_A_ROWS     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_B_COLS     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IN_PLACE   = 2'd3;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL    = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic [DIM_W-1:0] dim_t;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_MUL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  // effective sizes, already clamped to 1..MAX_DIM
  typedef struct packed {
    dim_t ar;
    dim_t kn;
    dim_t bc;
    logic in_place;
  } dims_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAC,
    BK_DRAIN,
    BK_EMIT,
    BK_WB
  } bk_state_t;

  function automatic dim_t eff_dim(input dim_t r);
    dim_t d;
    d = r;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (r > DIM_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

endpackage

/* rtl/mm_ram.sv */
// ----------------------------------------------------------------------------
// mm_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mm_front.sv */
// ----------------------------------------------------------------------------
// mm_front
// takes input transfers, drops ignored ones, turns the rest into commands
// ----------------------------------------------------------------------------
module mm_front
  import mm_pkg::*;
(
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,
  input  logic [OP_W-1:0]    s_tuser,
  input  dims_t              dims,
  input  logic               q_ready,
  output logic               push,
  output cmd_t               cmd
);

  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             keep;

  assign row = s_tdata[ROW_LSB +: ROW_W];
  assign col = s_tdata[COL_LSB +: COL_W];

  always_comb begin
    keep      = 1'b0;
    cmd.kind  = CMD_MUL;
    cmd.addr  = {row[IDX_W-1:0], col[IDX_W-1:0]};
    cmd.value = s_tdata[VAL_LSB +: VAL_W];
    unique case (s_tuser)
      OP_LOAD_A: begin
        cmd.kind = CMD_LOAD_A;
        keep     = (DIM_W'(row) < dims.ar) && (DIM_W'(col) < dims.kn);
      end
      OP_LOAD_B: begin
        cmd.kind = CMD_LOAD_B;
        keep     = (DIM_W'(row) < dims.kn) && (DIM_W'(col) < dims.bc);
      end
      OP_MUL: begin
        cmd.kind = CMD_MUL;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // dropped items are still taken, they just never reach the queue
  assign s_tready = q_ready;
  assign push     = s_tvalid && q_ready && keep;

endmodule

/* rtl/mm_queue.sv */
// ----------------------------------------------------------------------------
// mm_queue
// short command fifo between front and back
// ----------------------------------------------------------------------------
module mm_queue
  import mm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic ready,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

/* rtl/mm_back.sv */
// ----------------------------------------------------------------------------
// mm_back
// element stores, shared multiply-accumulate and result register
// ----------------------------------------------------------------------------
module mm_back
  import mm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dims_t              dims,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);

  bk_state_t state, state_next;

  logic [IDX_W-1:0] i, j, k, wbc;
  logic             i_last, j_last, k_last, wb_last, wb_en;

  // store ports
  logic              a_we, b_we;
  logic [ADDR_W-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [VAL_W-1:0]  a_wdata, b_wdata, a_rdata, b_rdata;
  logic [STORE_DEPTH-1:0] a_vld, b_vld;
  logic              a_rvld, b_rvld;

  // mac pipeline
  logic                    issue, acc_clr;
  logic                    rd_vld, prod_vld;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [VAL_W-1:0]         a_op, b_op;

  // result
  logic             slot_free, out_load;
  logic             fits, sat;
  logic [VAL_W-1:0] sat_val;
  logic [VAL_W-1:0] rowbuf [MAX_DIM];

  logic             o_vld, o_sat, o_last;
  logic [ROW_W-1:0] o_row;
  logic [COL_W-1:0] o_col;
  logic [VAL_W-1:0] o_val;

  assign i_last  = (DIM_W'(i) == dims.ar - DIM_W'(1));
  assign j_last  = (DIM_W'(j) == dims.bc - DIM_W'(1));
  assign k_last  = (DIM_W'(k) == dims.kn - DIM_W'(1));
  assign wb_last = (DIM_W'(wbc) == dims.bc - DIM_W'(1));
  assign wb_en   = dims.in_place && (dims.bc == dims.kn);

  assign slot_free = !o_vld || m_tready;

  mm_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_a_ram (
    .clk  (clk),
    .we   (a_we),
    .waddr(a_waddr),
    .wdata(a_wdata),
    .raddr(a_raddr),
    .rdata(a_rdata)
  );

  mm_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_b_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && q_cmd.kind == CMD_MUL) begin
          state_next = BK_MAC;
        end
      end
      BK_MAC: begin
        if (k_last) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!rd_vld && !prod_vld) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          if (!j_last) begin
            state_next = BK_MAC;
          end else if (wb_en) begin
            state_next = BK_WB;
          end else if (i_last) begin
            state_next = BK_IDLE;
          end else begin
            state_next = BK_MAC;
          end
        end
      end
      BK_WB: begin
        if (wb_last) begin
          state_next = i_last ? BK_IDLE : BK_MAC;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    a_we     = 1'b0;
    b_we     = 1'b0;
    a_waddr  = q_cmd.addr;
    a_wdata  = q_cmd.value;
    b_waddr  = q_cmd.addr;
    b_wdata  = q_cmd.value;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop = q_valid;
        a_we  = q_valid && q_cmd.kind == CMD_LOAD_A;
        b_we  = q_valid && q_cmd.kind == CMD_LOAD_B;
      end
      BK_MAC: begin
        issue = 1'b1;
      end
      BK_DRAIN: begin
      end
      BK_EMIT: begin
        out_load = slot_free;
      end
      BK_WB: begin
        a_we    = 1'b1;
        a_waddr = {i, wbc};
        a_wdata = rowbuf[wbc];
      end
      default: begin
      end
    endcase
  end

  assign a_raddr = {i, k};
  assign b_raddr = {k, j};
  assign acc_clr = issue && (k == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      i   <= '0;
      j   <= '0;
      k   <= '0;
      wbc <= '0;
    end else begin
      unique case (state)
        BK_IDLE: begin
          i <= '0;
          j <= '0;
          k <= '0;
        end
        BK_MAC: begin
          k <= k_last ? '0 : k + IDX_W'(1);
        end
        BK_DRAIN: begin
        end
        BK_EMIT: begin
          if (slot_free) begin
            wbc <= '0;
            if (!j_last) begin
              j <= j + IDX_W'(1);
            end else begin
              j <= '0;
              if (!wb_en) begin
                i <= i + IDX_W'(1);
              end
            end
          end
        end
        BK_WB: begin
          wbc <= wbc + IDX_W'(1);
          if (wb_last) begin
            i <= i + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= '0;
      b_vld <= '0;
    end else begin
      if (a_we) begin
        a_vld[a_waddr] <= 1'b1;
      end
      if (b_we) begin
        b_vld[b_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_rvld <= a_vld[a_raddr];
    b_rvld <= b_vld[b_raddr];
  end

  assign a_op = a_rvld ? a_rdata : '0;
  assign b_op = b_rvld ? b_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= issue;
      prod_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(a_op) * $signed(b_op);
    if (acc_clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // floor to q16.16 is dropping the low fraction bits, then clip
  assign fits    = (&acc[ACC_W-1:FRAC_BITS+VAL_W-1]) || !(|acc[ACC_W-1:FRAC_BITS+VAL_W-1]);
  assign sat     = !fits;
  assign sat_val = fits ? acc[FRAC_BITS +: VAL_W] : (acc[ACC_W-1] ? VAL_MIN : VAL_MAX);

  always_ff @(posedge clk) begin
    if (out_load) begin
      rowbuf[j] <= sat_val;
      o_row     <= ROW_W'(i);
      o_col     <= COL_W'(j);
      o_val     <= sat_val;
      o_sat     <= sat;
      o_last    <= i_last && j_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (out_load) begin
      o_vld <= 1'b1;
    end else if (m_tready) begin
      o_vld <= 1'b0;
    end
  end

  assign m_tvalid = o_vld;
  assign m_tdata  = {{PAD_W{1'b0}}, o_val, o_col, o_row};
  assign m_tuser  = o_sat;
  assign m_tlast  = o_last;

endmodule

/* rtl/matrix_multiply.sv */
// ----------------------------------------------------------------------------
// matrix_multiply
// dense C = A x B on signed q16.16 elements with saturated results
// ----------------------------------------------------------------------------
// Elements of A and B are loaded one per input transfer (operation 0 or 1,
// with row and column); loads outside the configured sizes and operation 3
// are taken and dropped. Operation 2 computes every element of C in
// row-major order and sends one output transfer per element, tlast on the
// final one, tuser high when the element was clipped to the 32-bit range.
// Each dot product is summed exactly, floored to q16.16 and saturated. With
// in_place set and a square B, each finished row of C is written back over
// the same row of A. In a multiply, every element walks the inner
// dimension through one shared 32x32 multiplier fed by the two store read
// ports, and the read/multiply/accumulate pipeline drains before each
// result is formed. A four-entry command queue lets loads and commands
// arrive while a multiply is still running. Both stores read as zero after
// reset without any clearing pass, so the block is ready as soon as reset
// is released. Sizes of 0 act as 1 and sizes above 8 act as 8.
// Configuration must be written by the user only while the block is idle;
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "matrix_multiply_macros.svh"

module matrix_multiply
  import mm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_W-1:0]     s_axis_tdata,   // row[2:0], col[5:3], value[37:6], zero pad
  input  logic [OP_W-1:0]        s_axis_tuser,   // operation[1:0]
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_W-1:0]     m_axis_tdata,   // out_row[2:0], out_col[5:3], out_value[37:6], zero pad
  output logic                   m_axis_tuser,   // saturated[0]
  output logic                   m_axis_tlast,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // raw register bits, clamped below
  dim_t  a_rows;
  dim_t  inner_size;
  dim_t  b_cols;
  logic  in_place;
  dims_t dims;

  logic  q_push, q_ready, q_pop, q_valid;
  cmd_t  push_cmd, q_head;

  // configuration is taken every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows     <= DIM_W'(MAX_DIM);
      inner_size <= DIM_W'(MAX_DIM);
      b_cols     <= DIM_W'(MAX_DIM);
      in_place   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_A_ROWS:     a_rows     <= cfg_data;
        REG_INNER_SIZE: inner_size <= cfg_data;
        REG_B_COLS:     b_cols     <= cfg_data;
        REG_IN_PLACE:   in_place   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // sizes the datapath actually uses
  assign dims.ar       = eff_dim(a_rows);
  assign dims.kn       = eff_dim(inner_size);
  assign dims.bc       = eff_dim(b_cols);
  assign dims.in_place = in_place;

  // front: accept and classify
  mm_front u_front (
    .s_tvalid(s_axis_tvalid),
    .s_tready(s_axis_tready),
    .s_tdata (s_axis_tdata),
    .s_tuser (s_axis_tuser),
    .dims    (dims),
    .q_ready (q_ready),
    .push    (q_push),
    .cmd     (push_cmd)
  );

  // command queue decouples the two halves
  mm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(push_cmd),
    .ready   (q_ready),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  // back: stores, mac and result register
  mm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .dims    (dims),
    .q_valid (q_valid),
    .q_cmd   (q_head),
    .q_pop   (q_pop),
    .m_tvalid(m_axis_tvalid),
    .m_tready(m_axis_tready),
    .m_tdata (m_axis_tdata),
    .m_tuser (m_axis_tuser),
    .m_tlast (m_axis_tlast)
  );

  // front never pushes into a full queue
  `MM_ASSERT(a_push_room, clk, rst, q_push |-> q_ready, "command pushed into full queue")
  // back never pops an empty queue
  `MM_ASSERT(a_pop_data, clk, rst, q_pop |-> q_valid, "command popped from empty queue")
  // a kept item lands in the queue on the next cycle
  `MM_ASSERT(a_push_lands, clk, rst, q_push |=> q_valid, "pushed command missing from queue")
  // reset leaves nothing pending on either side
  `MM_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !m_axis_tvalid && !q_valid, "state after reset")

endmodule
